/* rtl/core/sbie_pkg.sv */
// shared types and constants for the set bit index enumerator
package sbie_pkg;

  localparam int DefWordBits = 32;
  localparam int DefMaxWords = 1024;

  localparam int InWordW    = 32;
  localparam int IndexW     = 15;
  localparam int CountW     = 16;
  localparam int ModeW      = 2;
  localparam int LowByteW   = 8;
  localparam logic [LowByteW-1:0] LowByteMask = 8'hff;

  localparam logic [CountW-1:0] VecBitsReset = 16'h8000;
  localparam logic [CountW-1:0] CountMax     = 16'hffff;

  typedef enum logic [ModeW-1:0] {
    MODE_PLAIN    = 2'd0,
    MODE_SKIP_LOW = 2'd1,
    MODE_INVERT   = 2'd2
  } mode_e;

  typedef enum logic {
    REG_MODE     = 1'b0,
    REG_VEC_BITS = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COUNT
  } state_e;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [CountW-1:0] vector_bits;
  } cfg_t;

endpackage

/* rtl/core/sbie_regs.sv */
// configuration registers behind the apb-style port
module sbie_regs
  import sbie_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [ModeW-1:0]  mode_q, mode_d;
  logic [CountW-1:0] vec_bits_q, vec_bits_d;
  logic              wr_en;
  reg_e              reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = reg_e'(paddr[2]);

  always_comb begin
    mode_d     = mode_q;
    vec_bits_d = vec_bits_q;
    if (wr_en) begin
      case (reg_sel)
        REG_MODE:     mode_d     = pwdata[ModeW-1:0];
        REG_VEC_BITS: vec_bits_d = pwdata[CountW-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MODE:     prdata = {{(32-ModeW){1'b0}}, mode_q};
      REG_VEC_BITS: prdata = {{(32-CountW){1'b0}}, vec_bits_q};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_PLAIN;
      vec_bits_q <= VecBitsReset;
    end else begin
      mode_q     <= mode_d;
      vec_bits_q <= vec_bits_d;
    end
  end

  assign cfg_o.mode        = mode_q;
  assign cfg_o.vector_bits = vec_bits_q;

endmodule

/* rtl/core/sbie_seq.sv */
// registered bit scan sequencer: one shift/compare step per cycle unless stalled
module sbie_seq
  import sbie_pkg::*;
#(
  parameter int WORD_BITS = DefWordBits,
  parameter int MAX_WORDS = DefMaxWords
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [WORD_BITS-1:0] in_word_i,
  input  logic                 in_last_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [IndexW-1:0]    out_index_o,
  output logic                 out_is_count_o,
  output logic [CountW-1:0]    out_total_o,
  output logic                 out_run_end_o
);

  localparam int PosW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int BitW  = $clog2(WORD_BITS);
  localparam int IdxW  = $clog2(MAX_WORDS * WORD_BITS);
  localparam int CmpW  = (IdxW > CountW) ? IdxW : CountW;
  localparam logic [WORD_BITS-1:0] LowMask = WORD_BITS'(LowByteMask);

  state_e                state_q, state_d;
  logic [WORD_BITS-1:0]  word_q, word_d;
  logic                  last_q, last_d;
  logic [BitW-1:0]       bit_q, bit_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [IdxW-1:0]       base_q, base_d;
  logic [PosW-1:0]       pos_q, pos_d;
  logic [CountW-1:0]     count_q, count_d;
  logic                  out_valid_q, out_valid_d;
  logic [IndexW-1:0]     out_index_q, out_index_d;
  logic                  out_is_count_q, out_is_count_d;
  logic [CountW-1:0]     out_total_q, out_total_d;

  logic                  out_free;
  logic                  sel;
  logic [CmpW-1:0]       idx_ext;

  assign idx_ext  = CmpW'(idx_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign sel      = word_q[0] && (idx_ext < CmpW'(cfg_i.vector_bits));

  always_comb begin
    state_d        = state_q;
    word_d         = word_q;
    last_d         = last_q;
    bit_d          = bit_q;
    idx_d          = idx_q;
    base_d         = base_q;
    pos_d          = pos_q;
    count_d        = count_q;
    out_valid_d    = out_valid_q;
    out_index_d    = out_index_q;
    out_is_count_d = out_is_count_q;
    out_total_d    = out_total_q;
    in_ready_o     = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if ((cfg_i.mode == MODE_SKIP_LOW) && (pos_q == '0)) begin
            word_d = in_word_i & ~LowMask;
          end else begin
            word_d = in_word_i;
          end
          last_d  = in_last_i;
          bit_d   = '0;
          idx_d   = base_q;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!sel || out_free) begin
          word_d = word_q >> 1;
          idx_d  = idx_q + IdxW'(1);
          bit_d  = bit_q + BitW'(1);
          if (sel) begin
            out_valid_d    = 1'b1;
            out_index_d    = idx_ext[IndexW-1:0];
            out_is_count_d = 1'b0;
            out_total_d    = '0;
            if (count_q != CountMax) begin
              count_d = count_q + CountW'(1);
            end
          end
          if (bit_q == BitW'(WORD_BITS - 1)) begin
            if (last_q) begin
              state_d = ST_COUNT;
            end else begin
              state_d = ST_IDLE;
              if (pos_q == PosW'(MAX_WORDS - 1)) begin
                pos_d  = '0;
                base_d = '0;
              end else begin
                pos_d  = pos_q + PosW'(1);
                base_d = base_q + IdxW'(WORD_BITS);
              end
            end
          end
        end
      end
      ST_COUNT: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_index_d    = '0;
          out_is_count_d = 1'b1;
          out_total_d    = count_q;
          pos_d          = '0;
          base_d         = '0;
          count_d        = '0;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      base_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      base_q      <= base_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q         <= word_d;
    last_q         <= last_d;
    bit_q          <= bit_d;
    idx_q          <= idx_d;
    out_index_q    <= out_index_d;
    out_is_count_q <= out_is_count_d;
    out_total_q    <= out_total_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_index_o    = out_index_q;
  assign out_is_count_o = out_is_count_q;
  assign out_total_o    = out_total_q;
  assign out_run_end_o  = out_is_count_q;

endmodule

/* rtl/core/set_bit_index_enumerator_core.sv */
// top level of the set bit index enumerator
// A bit vector arrives on the slave stream one 32-bit word per beat, lowest
// word first; tlast marks the final word of the vector. For every selected
// bit below vector_bits the master stream carries one beat with the bit's
// absolute index, in ascending order; after the last word one more beat has
// tuser high, the total count of enumerated bits and tlast high.
// mode selects plain listing, listing with the low byte of word 0 skipped,
// or listing of clear bits; both registers sit on the apb-style port, and
// the user is to write them only while the block is idle; the block itself
// does not enforce this. Each word is accepted in ST_IDLE and scanned in
// ST_SCAN, one bit per cycle through the shared shift and compare step
// unless a selected bit waits for the output register; after the last word
// ST_COUNT sends the count beat. tready on the slave side is low outside
// ST_IDLE. Results pass through a one-beat output register; when the receiver
// stalls the scan holds on the next selected bit until the register is free.
// Reset clears the word position, the running count and the output valid,
// and loads mode 0 and vector_bits 32768.
module set_bit_index_enumerator_core
  import sbie_pkg::*;
#(
  parameter int WORD_BITS = DefWordBits,
  parameter int MAX_WORDS = DefMaxWords
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // word_value
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // bit_index[14:0], total_count[30:15], zero
  output logic        m_axis_tuser,   // is_count
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t                 cfg;
  logic [WORD_BITS-1:0] word_ext;
  logic [WORD_BITS-1:0] word_sel;
  logic [IndexW-1:0]    out_index;
  logic [CountW-1:0]    out_total;

  generate
    if (WORD_BITS >= InWordW) begin : g_wide
      assign word_ext = WORD_BITS'(s_axis_tdata);
    end else begin : g_narrow
      assign word_ext = s_axis_tdata[WORD_BITS-1:0];
    end
  endgenerate

  assign word_sel = (cfg.mode == MODE_INVERT) ? ~word_ext : word_ext;

  sbie_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sbie_seq #(
    .WORD_BITS (WORD_BITS),
    .MAX_WORDS (MAX_WORDS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_word_i      (word_sel),
    .in_last_i      (s_axis_tlast),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_index_o    (out_index),
    .out_is_count_o (m_axis_tuser),
    .out_total_o    (out_total),
    .out_run_end_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_total, out_index};

endmodule
